// ===== design/ddo_pkg.sv =====
// shared constants, types and tables for the wheel odometry block
package ddo_pkg;

    // word widths
    localparam int ANGLE_W = 32;
    localparam int RAD_W   = 16;
    localparam int SEP_W   = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEP    = 2'd1;

    // configuration reset values
    localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd2163;
    localparam logic [SEP_W-1:0] SEP_RESET    = 24'd11141;

    // cordic setup
    localparam int CORDIC_STEPS = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // radians (Q16.16) to binary angle, scaled by 2^24
    localparam logic signed [39:0] RAD_TO_BA = 40'sd174992710548;
    // microseconds per second
    localparam logic signed [39:0] US_PER_S  = 40'sd1000000;
    // magnitude clamp for the speed numerators, 2^44
    localparam logic [51:0] SPEED_CLAMP = 52'd17592186044416;

    // divider length in quotient bits
    localparam int DIV_BITS = 64;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE = 4'd0,
        OP_DS   = 4'd1,
        OP_TH   = 4'd2,
        OP_DTH  = 4'd3,
        OP_BA   = 4'd4,
        OP_COS  = 4'd5,
        OP_PX   = 4'd6,
        OP_PY   = 4'd7,
        OP_HALF = 4'd8,
        OP_VLM  = 4'd9,
        OP_VLD  = 4'd10,
        OP_VAM  = 4'd11,
        OP_VAD  = 4'd12
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic go;
        op_t  op;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic done;
        logic dt_zero;
        logic out_busy;
    } stat_t;

    // arctangent of 2^-i as binary angle
    function automatic logic [31:0] atan_ba(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/ddo_ctrl.sv =====
// sequencer that steps the odometry datapath through one word
module ddo_ctrl
    import ddo_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t st,
    output cmd_t  cmd
);

    typedef enum logic [13:0] {
        ST_IDLE = 14'h0001,
        ST_DS   = 14'h0002,
        ST_TH   = 14'h0004,
        ST_DTH  = 14'h0008,
        ST_BA   = 14'h0010,
        ST_COS  = 14'h0020,
        ST_PX   = 14'h0040,
        ST_PY   = 14'h0080,
        ST_HALF = 14'h0100,
        ST_VLM  = 14'h0200,
        ST_VLD  = 14'h0400,
        ST_VAM  = 14'h0800,
        ST_VAD  = 14'h1000,
        ST_DONE = 14'h2000
    } state_t;

    state_t state_reg, state_next;
    logic   go_reg, go_next;
    op_t    op;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_DS;
            ST_DS:   if (st.done) state_next = ST_TH;
            ST_TH:   if (st.done) state_next = ST_DTH;
            ST_DTH:  if (st.done) state_next = ST_BA;
            ST_BA:   if (st.done) state_next = ST_COS;
            ST_COS:  if (st.done) state_next = ST_PX;
            ST_PX:   if (st.done) state_next = ST_PY;
            ST_PY:   if (st.done) state_next = ST_HALF;
            ST_HALF: if (st.done) state_next = st.dt_zero ? ST_DONE : ST_VLM;
            ST_VLM:  if (st.done) state_next = ST_VLD;
            ST_VLD:  if (st.done) state_next = ST_VAM;
            ST_VAM:  if (st.done) state_next = ST_VAD;
            ST_VAD:  if (st.done) state_next = ST_DONE;
            ST_DONE: if (!st.out_busy) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // launch a unit on entry to each compute state
    assign go_next = (state_next != state_reg) && (state_next != ST_IDLE) &&
                     (state_next != ST_DONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            go_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            go_reg    <= go_next;
        end
    end

    // operation per state
    always_comb begin
        unique case (state_reg)
            ST_DS:   op = OP_DS;
            ST_TH:   op = OP_TH;
            ST_DTH:  op = OP_DTH;
            ST_BA:   op = OP_BA;
            ST_COS:  op = OP_COS;
            ST_PX:   op = OP_PX;
            ST_PY:   op = OP_PY;
            ST_HALF: op = OP_HALF;
            ST_VLM:  op = OP_VLM;
            ST_VLD:  op = OP_VLD;
            ST_VAM:  op = OP_VAM;
            ST_VAD:  op = OP_VAD;
            default: op = OP_NONE;
        endcase
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign cmd.take   = (state_reg == ST_IDLE) && s_valid;
    assign cmd.go     = go_reg;
    assign cmd.op     = op;
    assign cmd.finish = (state_reg == ST_DONE) && !st.out_busy;

endmodule

// ===== design/ddo_datapath.sv =====
// odometry datapath: multiplier, divider, cordic, pose state and output word
module ddo_datapath
    import ddo_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cmd_t                        cmd,
    output stat_t                       st,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DAT_W-1:0]        cfg_data,
    input  logic signed [ANGLE_W-1:0]   s_left_wheel_angle,
    input  logic signed [ANGLE_W-1:0]   s_right_wheel_angle,
    input  logic [31:0]                 s_stamp_us,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [31:0]          m_x_position,
    output logic signed [31:0]          m_y_position,
    output logic [31:0]                 m_heading,
    output logic signed [31:0]          m_linear_speed,
    output logic signed [31:0]          m_angular_speed,
    output logic signed [15:0]          m_quat_z,
    output logic signed [15:0]          m_quat_w,
    output logic                        m_bad_interval
);

    // |v| clamped for the speed numerators
    function automatic logic [51:0] abs_clamp(input logic signed [51:0] v);
        logic [51:0] mag;
        mag = v[51] ? 52'(-v) : 52'(v);
        return (mag > SPEED_CLAMP) ? SPEED_CLAMP : mag;
    endfunction

    // signed saturation of a rounded quotient
    function automatic logic [31:0] sat32(input logic [63:0] q, input logic neg);
        logic [31:0] r;
        if (neg) begin
            r = (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q[31:0]);
        end else begin
            r = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end
        return r;
    endfunction

    // Q2.30 rounded half up to Q1.15 with saturation
    function automatic logic [15:0] sat16(input logic signed [33:0] v);
        logic signed [33:0] t;
        logic signed [18:0] s;
        t = v + 34'sd16384;
        s = t[33:15];
        if (s > 19'sd32767) begin
            return 16'h7FFF;
        end else if (s < -19'sd32768) begin
            return 16'h8000;
        end else begin
            return s[15:0];
        end
    endfunction

    // configuration and pose state
    logic [RAD_W-1:0]          rad_reg;
    logic [SEP_W-1:0]          sep_reg;
    logic signed [31:0]        last_l_reg, last_r_reg;
    logic [31:0]               last_t_reg;
    logic signed [31:0]        px_reg, py_reg;
    logic [31:0]               hd_reg;

    // captured input word
    logic signed [31:0]        in_l_reg, in_r_reg;
    logic [31:0]               in_t_reg;

    // intermediate results
    logic signed [34:0]        ds_reg;
    logic signed [50:0]        num_reg;
    logic signed [51:0]        dth_reg;
    logic signed [33:0]        c_reg, s_reg;
    logic [63:0]               prod_reg;
    logic [31:0]               lin_reg, ang_reg;
    logic [15:0]               qz_reg, qw_reg;

    // multiplier
    logic signed [51:0]        ma_reg;
    logic signed [39:0]        mb_reg;
    logic signed [72:0]        p1_reg;
    logic signed [91:0]        mp_reg;
    logic [1:0]                mph_reg;

    // divider
    logic [63:0]               dn_reg;
    logic [31:0]               rem_reg, dd_reg;
    logic [6:0]                dc_reg;
    logic                      dbusy_reg;

    // cordic
    logic signed [33:0]        cx_reg, cy_reg;
    logic signed [32:0]        cz_reg;
    logic                      cneg_reg, cbusy_reg;
    logic [5:0]                cc_reg;

    // output word
    logic                      mv_reg;
    logic signed [31:0]        ox_reg, oy_reg, olin_reg, oang_reg;
    logic [31:0]               ohd_reg;
    logic [15:0]               oqz_reg, oqw_reg;
    logic                      obad_reg;

    // wheel deltas and elapsed time
    logic signed [32:0]        dl, dr;
    logic signed [33:0]        sum, diff;
    logic [31:0]               dt;
    logic [SEP_W-1:0]          sep_eff;

    assign dl      = 33'(in_l_reg) - 33'(last_l_reg);
    assign dr      = 33'(in_r_reg) - 33'(last_r_reg);
    assign sum     = 34'(dr) + 34'(dl);
    assign diff    = 34'(dr) - 34'(dl);
    assign dt      = in_t_reg - last_t_reg;
    assign sep_eff = (sep_reg == '0) ? SEP_W'(1) : sep_reg;

    // unit classes
    logic is_mul, is_div, is_cor;
    assign is_mul = (cmd.op == OP_DS) || (cmd.op == OP_TH) || (cmd.op == OP_BA) ||
                    (cmd.op == OP_PX) || (cmd.op == OP_PY) || (cmd.op == OP_VLM) ||
                    (cmd.op == OP_VAM);
    assign is_div = (cmd.op == OP_DTH) || (cmd.op == OP_VLD) || (cmd.op == OP_VAD);
    assign is_cor = (cmd.op == OP_COS) || (cmd.op == OP_HALF);

    // multiplier operand select
    logic signed [51:0] ma_sel;
    logic signed [39:0] mb_sel;
    always_comb begin
        ma_sel = '0;
        mb_sel = '0;
        unique case (cmd.op)
            OP_DS:  begin ma_sel = 52'(sum);  mb_sel = 40'($signed({1'b0, rad_reg})); end
            OP_TH:  begin ma_sel = 52'(diff); mb_sel = 40'($signed({1'b0, rad_reg})); end
            OP_BA:  begin ma_sel = dth_reg;   mb_sel = RAD_TO_BA; end
            OP_PX:  begin ma_sel = 52'(ds_reg); mb_sel = 40'(c_reg); end
            OP_PY:  begin ma_sel = 52'(ds_reg); mb_sel = 40'(s_reg); end
            OP_VLM: begin ma_sel = $signed(abs_clamp(52'(ds_reg))); mb_sel = US_PER_S; end
            OP_VAM: begin ma_sel = $signed(abs_clamp(dth_reg)); mb_sel = US_PER_S; end
            default: begin ma_sel = '0; mb_sel = '0; end
        endcase
    end

    // two partial products, low half unsigned then high half signed
    logic signed [72:0] p_lo;
    logic signed [91:0] p_hi;
    assign p_lo = $signed({{21{ma_reg[51]}}, ma_reg}) *
                  $signed({53'd0, mb_reg[19:0]});
    assign p_hi = $signed({{40{ma_reg[51]}}, ma_reg}) *
                  $signed({{72{mb_reg[39]}}, mb_reg[39:20]});

    logic mul_done;
    assign mul_done = (mph_reg == 2'd3);

    // divider operand select and restoring step
    logic [50:0] nmag;
    logic [63:0] dn_sel;
    logic [31:0] dd_sel;
    always_comb begin
        nmag   = num_reg[50] ? 51'(-num_reg) : 51'(num_reg);
        dn_sel = '0;
        dd_sel = 32'd1;
        unique case (cmd.op)
            OP_DTH: begin
                dn_sel = 64'(nmag) + 64'(sep_eff >> 1);
                dd_sel = 32'(sep_eff);
            end
            OP_VLD, OP_VAD: begin
                dn_sel = prod_reg + 64'(dt >> 1);
                dd_sel = dt;
            end
            default: begin
                dn_sel = '0;
                dd_sel = 32'd1;
            end
        endcase
    end

    logic [32:0] trial;
    logic        trial_ge;
    assign trial    = {rem_reg, dn_reg[63]};
    assign trial_ge = (trial >= {1'b0, dd_reg});

    logic div_done;
    assign div_done = dbusy_reg && (dc_reg == '0);

    // cordic start angle with half-turn fold
    logic [31:0]        ba_sel;
    logic signed [32:0] z0;
    logic signed [32:0] z_fold;
    logic               neg0;
    always_comb begin
        ba_sel = (cmd.op == OP_HALF) ? {1'b0, hd_reg[31:1]} : hd_reg;
        z0     = 33'($signed(ba_sel));
        z_fold = z0;
        neg0   = 1'b0;
        if (z0 > 33'sd1073741824) begin
            z_fold = z0 - 33'sd2147483648;
            neg0   = 1'b1;
        end else if (z0 < -33'sd1073741824) begin
            z_fold = z0 + 33'sd2147483648;
            neg0   = 1'b1;
        end
    end

    // one micro-rotation
    logic [4:0]         ci;
    logic signed [33:0] cx_sh, cy_sh;
    logic signed [32:0] at;
    assign ci    = cc_reg[4:0];
    assign cx_sh = cx_reg >>> ci;
    assign cy_sh = cy_reg >>> ci;
    assign at    = $signed({1'b0, atan_ba(ci)});

    logic cor_done;
    assign cor_done = cbusy_reg && (cc_reg == 6'(CORDIC_STEPS));

    logic signed [33:0] cx_fin, cy_fin;
    assign cx_fin = cneg_reg ? -cx_reg : cx_reg;
    assign cy_fin = cneg_reg ? -cy_reg : cy_reg;

    // rounded product slices
    logic signed [91:0] r_ds, r_ba, r_pos;
    assign r_ds  = mp_reg + 92'sd65536;
    assign r_ba  = mp_reg + 92'sd8388608;
    assign r_pos = mp_reg + 92'sd536870912;

    // control state of the units and the output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rad_reg    <= RADIUS_RESET;
            sep_reg    <= SEP_RESET;
            last_l_reg <= '0;
            last_r_reg <= '0;
            last_t_reg <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            hd_reg     <= '0;
            mph_reg    <= '0;
            dbusy_reg  <= 1'b0;
            cbusy_reg  <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            // register writes
            if (cfg_valid) begin
                if (cfg_index == REG_RADIUS) rad_reg <= cfg_data[RAD_W-1:0];
                if (cfg_index == REG_SEP)    sep_reg <= cfg_data[SEP_W-1:0];
            end

            // multiplier phases
            unique case (mph_reg)
                2'd0: if (cmd.go && is_mul) mph_reg <= 2'd1;
                2'd1: mph_reg <= 2'd2;
                2'd2: mph_reg <= 2'd3;
                default: mph_reg <= 2'd0;
            endcase

            // divider run
            if (cmd.go && is_div) begin
                dbusy_reg <= 1'b1;
            end else if (div_done) begin
                dbusy_reg <= 1'b0;
            end

            // cordic run
            if (cmd.go && is_cor) begin
                cbusy_reg <= 1'b1;
            end else if (cor_done) begin
                cbusy_reg <= 1'b0;
            end

            // pose updates
            if (mul_done && (cmd.op == OP_BA)) hd_reg <= hd_reg + r_ba[55:24];
            if (mul_done && (cmd.op == OP_PX)) px_reg <= px_reg + r_pos[61:30];
            if (mul_done && (cmd.op == OP_PY)) py_reg <= py_reg + r_pos[61:30];

            // output word handshake
            if (cmd.finish) begin
                mv_reg     <= 1'b1;
                last_l_reg <= in_l_reg;
                last_r_reg <= in_r_reg;
                last_t_reg <= in_t_reg;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            in_l_reg <= s_left_wheel_angle;
            in_r_reg <= s_right_wheel_angle;
            in_t_reg <= s_stamp_us;
        end

        // multiplier
        if (cmd.go && is_mul) begin
            ma_reg <= ma_sel;
            mb_reg <= mb_sel;
        end
        if (mph_reg == 2'd1) p1_reg <= p_lo;
        if (mph_reg == 2'd2) mp_reg <= 92'(p1_reg) + (p_hi <<< 20);

        // divider
        if (cmd.go && is_div) begin
            dn_reg  <= dn_sel;
            dd_reg  <= dd_sel;
            rem_reg <= '0;
            dc_reg  <= 7'(DIV_BITS);
        end else if (dbusy_reg && (dc_reg != '0)) begin
            rem_reg <= trial_ge ? 32'(trial - {1'b0, dd_reg}) : trial[31:0];
            dn_reg  <= {dn_reg[62:0], trial_ge};
            dc_reg  <= dc_reg - 7'd1;
        end

        // cordic
        if (cmd.go && is_cor) begin
            cx_reg   <= CORDIC_GAIN;
            cy_reg   <= '0;
            cz_reg   <= z_fold;
            cneg_reg <= neg0;
            cc_reg   <= '0;
        end else if (cbusy_reg && !cor_done) begin
            if (!cz_reg[32]) begin
                cx_reg <= cx_reg - cy_sh;
                cy_reg <= cy_reg + cx_sh;
                cz_reg <= cz_reg - at;
            end else begin
                cx_reg <= cx_reg + cy_sh;
                cy_reg <= cy_reg - cx_sh;
                cz_reg <= cz_reg + at;
            end
            cc_reg <= cc_reg + 6'd1;
        end

        // result capture
        if (mul_done) begin
            unique case (cmd.op)
                OP_DS:  ds_reg  <= r_ds[51:17];
                OP_TH:  num_reg <= mp_reg[50:0];
                OP_VLM, OP_VAM: prod_reg <= mp_reg[63:0];
                default: ;
            endcase
        end
        if (div_done) begin
            unique case (cmd.op)
                OP_DTH: dth_reg <= num_reg[50] ? -$signed(dn_reg[51:0])
                                               : $signed(dn_reg[51:0]);
                OP_VLD: lin_reg <= sat32(dn_reg, ds_reg[34]);
                OP_VAD: ang_reg <= sat32(dn_reg, dth_reg[51]);
                default: ;
            endcase
        end
        if (cor_done) begin
            if (cmd.op == OP_COS) begin
                c_reg <= cx_fin;
                s_reg <= cy_fin;
            end else begin
                qz_reg <= sat16(cy_fin);
                qw_reg <= sat16(cx_fin);
            end
        end

        // output word load
        if (cmd.finish) begin
            ox_reg   <= px_reg;
            oy_reg   <= py_reg;
            ohd_reg  <= hd_reg;
            olin_reg <= (dt == '0) ? '0 : $signed(lin_reg);
            oang_reg <= (dt == '0) ? '0 : $signed(ang_reg);
            oqz_reg  <= qz_reg;
            oqw_reg  <= qw_reg;
            obad_reg <= (dt == '0);
        end
    end

    assign st.done     = mul_done || div_done || cor_done;
    assign st.dt_zero  = (dt == '0);
    assign st.out_busy = mv_reg && !m_ready;

    assign cfg_ready       = 1'b1;
    assign m_valid         = mv_reg;
    assign m_x_position    = ox_reg;
    assign m_y_position    = oy_reg;
    assign m_heading       = ohd_reg;
    assign m_linear_speed  = olin_reg;
    assign m_angular_speed = oang_reg;
    assign m_quat_z        = $signed(oqz_reg);
    assign m_quat_w        = $signed(oqw_reg);
    assign m_bad_interval  = obad_reg;

endmodule

// ===== design/diff_drive_odometry_top.sv =====
// top level of the differential drive wheel odometry block
// Each word of absolute wheel angles and a time stamp updates the pose and gives
// one result word. Each word runs the 64-step radix-2 divider, once for the
// heading change and twice for the speeds (skipped when the elapsed time is
// zero), the 24-step CORDIC, run for the heading and the half heading, and a
// shared multiplier used up to seven times. A new word is taken once the
// previous one has been handed to the output register, which holds it until
// m_ready. Register writes are taken at any time and must only be issued
// while the block is idle.
module diff_drive_odometry_top
    import ddo_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DAT_W-1:0]        cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [31:0]          s_left_wheel_angle,
    input  logic signed [31:0]          s_right_wheel_angle,
    input  logic [31:0]                 s_stamp_us,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [31:0]          m_x_position,
    output logic signed [31:0]          m_y_position,
    output logic [31:0]                 m_heading,
    output logic signed [31:0]          m_linear_speed,
    output logic signed [31:0]          m_angular_speed,
    output logic signed [15:0]          m_quat_z,
    output logic signed [15:0]          m_quat_w,
    output logic                        m_bad_interval
);

    cmd_t  cmd;
    stat_t st;

    // sequencer
    ddo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // arithmetic and state
    ddo_datapath u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .st                  (st),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_left_wheel_angle  (s_left_wheel_angle),
        .s_right_wheel_angle (s_right_wheel_angle),
        .s_stamp_us          (s_stamp_us),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_x_position        (m_x_position),
        .m_y_position        (m_y_position),
        .m_heading           (m_heading),
        .m_linear_speed      (m_linear_speed),
        .m_angular_speed     (m_angular_speed),
        .m_quat_z            (m_quat_z),
        .m_quat_w            (m_quat_w),
        .m_bad_interval      (m_bad_interval)
    );

endmodule
